@@ hdl/array_list_engine_macros.svh @@
// Assertion helpers for the checker file.
// Both macros expect clk and rst_n in scope.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication
`define ALE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ALE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ale_pkg.sv @@
package ale_pkg;

    // Operation codes
    localparam logic [2:0] OP_APPEND      = 3'd0;
    localparam logic [2:0] OP_INSERT      = 3'd1;
    localparam logic [2:0] OP_REMOVE_LAST = 3'd2;
    localparam logic [2:0] OP_REMOVE_AT   = 3'd3;
    localparam logic [2:0] OP_OVERWRITE   = 3'd4;
    localparam logic [2:0] OP_SEARCH      = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [4:0]  position;
        logic [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [4:0] found_index;
        logic [5:0] count;
        logic       is_empty;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_INS_WR,
        S_SHIFT_DN,
        S_SEARCH
    } state_t;

endpackage

@@ hdl/ale_ram.sv @@
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/array_list_engine.sv @@
// Bounded ordered list engine.
// A request is taken when start is high and busy is low; it carries an
// operation, a position and a value. Exactly one result comes back per
// request, shown on rsp for one cycle with done high; it must be taken then.
// Append, remove last and overwrite, insert at the count, remove at the last
// position, search of an empty list, unused codes and any request rejected
// by its checks answer in the cycle after acceptance and leave busy low.
// Insert at a position p below the count moves count-p elements. Remove at
// position p moves count-p-1 elements. Search reads one element per cycle
// from index zero and stops at the first hit or after the last element.
// Busy is high meanwhile and drops in the result cycle, so the next item
// can be taken at the edge that takes a result. The element memory has one
// registered read and one write per cycle, so a shift or a scan moves one
// element a cycle.
// Reset empties the list (count zero) and returns the sequencer to idle;
// the memory holds no reset value and no data read beyond the count is used.
module array_list_engine #(
    parameter int CAPACITY      = 32,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ale_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output ale_pkg::rsp_t rsp
);

    import ale_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    // wide enough for position+1 and the count
    localparam int CMPW = (CW > 6) ? CW : 6;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            ptr_reg, ptr_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic [ELEMENT_WIDTH-1:0] val_reg, val_next;
    logic                     done_reg, done_next;
    rsp_t                     rsp_reg, rsp_next;

    // Memory port signals
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [ELEMENT_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [ELEMENT_WIDTH-1:0] mem_rdata;

    // Request decode
    logic                     accept;
    logic                     is_full;
    logic                     is_zero;
    logic [CMPW-1:0]          cnt_x;
    logic [CMPW-1:0]          pos_x;
    logic [AW-1:0]            req_pos;
    logic [ELEMENT_WIDTH-1:0] req_val;

    // Step results
    logic [1:0]               status_w;
    logic                     hit_w;
    logic                     fin_w;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign is_full = (count_reg == CW'(CAPACITY));
    assign is_zero = (count_reg == '0);
    assign cnt_x   = CMPW'(count_reg);
    assign pos_x   = CMPW'(req.position);
    assign req_pos = AW'(req.position);
    assign req_val = ELEMENT_WIDTH'(req.value);

    ale_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ale_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        OP_INSERT:
                        begin
                            if (!is_full && (pos_x < cnt_x))
                            begin
                                state_next = S_SHIFT_UP;
                            end
                        end
                        OP_REMOVE_AT:
                        begin
                            if (!is_zero && ((pos_x + CMPW'(1)) < cnt_x))
                            begin
                                state_next = S_SHIFT_DN;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (!is_zero)
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                if (ptr_reg == (pos_reg + AW'(1)))
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                state_next = S_IDLE;
            end
            S_SHIFT_DN:
            begin
                if (!((CW'(ptr_reg) + CW'(2)) < count_reg))
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if ((mem_rdata == val_reg) || !((CW'(ptr_reg) + CW'(1)) < count_reg))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        mem_we     = 1'b0;
        mem_waddr  = ptr_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = '0;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        status_w   = ST_OK;
        hit_w      = 1'b0;
        fin_w      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pos_next = req_pos;
                    val_next = req_val;
                    case (req.op)
                        OP_APPEND:
                        begin
                            fin_w = 1'b1;
                            if (is_full)
                            begin
                                status_w = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = req_val;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_w = ST_FULL;
                                fin_w    = 1'b1;
                            end
                            else if (pos_x > cnt_x)
                            begin
                                status_w = ST_BADPOS;
                                fin_w    = 1'b1;
                            end
                            else if (pos_x == cnt_x)
                            begin
                                // insert at the end is an append
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = req_val;
                                count_next = count_reg + CW'(1);
                                fin_w      = 1'b1;
                            end
                            else
                            begin
                                // move the tail up, starting at the last element
                                mem_raddr = AW'(count_reg - CW'(1));
                                ptr_next  = AW'(count_reg);
                            end
                        end
                        OP_REMOVE_LAST:
                        begin
                            fin_w = 1'b1;
                            if (is_zero)
                            begin
                                status_w = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        OP_REMOVE_AT:
                        begin
                            if (is_zero)
                            begin
                                status_w = ST_EMPTY;
                                fin_w    = 1'b1;
                            end
                            else if (pos_x >= cnt_x)
                            begin
                                status_w = ST_BADPOS;
                                fin_w    = 1'b1;
                            end
                            else if ((pos_x + CMPW'(1)) == cnt_x)
                            begin
                                count_next = count_reg - CW'(1);
                                fin_w      = 1'b1;
                            end
                            else
                            begin
                                // move the tail down, starting just above pos
                                mem_raddr = req_pos + AW'(1);
                                ptr_next  = req_pos;
                            end
                        end
                        OP_OVERWRITE:
                        begin
                            fin_w = 1'b1;
                            if (is_zero)
                            begin
                                status_w = ST_EMPTY;
                            end
                            else if (pos_x >= cnt_x)
                            begin
                                status_w = ST_BADPOS;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = req_pos;
                                mem_wdata = req_val;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (is_zero)
                            begin
                                fin_w = 1'b1;
                            end
                            else
                            begin
                                mem_raddr = '0;
                                ptr_next  = '0;
                            end
                        end
                        default:
                        begin
                            fin_w = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                // element ptr-1 arrives, lands at ptr
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                if (ptr_reg != (pos_reg + AW'(1)))
                begin
                    mem_raddr = ptr_reg - AW'(2);
                    ptr_next  = ptr_reg - AW'(1);
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                fin_w      = 1'b1;
            end
            S_SHIFT_DN:
            begin
                // element ptr+1 arrives, lands at ptr
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                if ((CW'(ptr_reg) + CW'(2)) < count_reg)
                begin
                    mem_raddr = ptr_reg + AW'(2);
                    ptr_next  = ptr_reg + AW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    fin_w      = 1'b1;
                end
            end
            S_SEARCH:
            begin
                // element ptr arrives, compare against the key
                if (mem_rdata == val_reg)
                begin
                    hit_w = 1'b1;
                    fin_w = 1'b1;
                end
                else if ((CW'(ptr_reg) + CW'(1)) < count_reg)
                begin
                    mem_raddr = ptr_reg + AW'(1);
                    ptr_next  = ptr_reg + AW'(1);
                end
                else
                begin
                    fin_w = 1'b1;
                end
            end
            default:
            begin
                fin_w = 1'b0;
            end
        endcase
    end

    // Result assembly
    always_comb
    begin
        done_next            = fin_w;
        rsp_next.status      = status_w;
        rsp_next.found       = hit_w;
        rsp_next.found_index = hit_w ? 5'(ptr_reg) : 5'd0;
        rsp_next.count       = 6'(count_next);
        rsp_next.is_empty    = (count_next == '0);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        pos_reg <= pos_next;
        val_reg <= val_next;
        rsp_reg <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ hdl/ale_checker.sv @@
`include "array_list_engine_macros.svh"

module ale_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input ale_pkg::rsp_t rsp
);

    import ale_pkg::*;

    // A result marks the end of work on its item
    `ALE_ASSERT_NOW(a_done_not_busy, done, !busy, "result shown while still busy")

    // An accepted item either answers at once or keeps the block busy
    `ALE_ASSERT_NEXT(a_accept_progress, start && !busy, done || busy, "accepted item dropped")

    // Empty flag follows the count
    `ALE_ASSERT_NOW(a_empty_flag, done, rsp.is_empty == (rsp.count == 6'd0), "empty flag mismatch")

    // Index is zero without a hit
    `ALE_ASSERT_NOW(a_index_zero, done && !rsp.found, rsp.found_index == 5'd0, "stray found index")

    // A hit only comes with an ok status
    `ALE_ASSERT_NOW(a_hit_ok, done && rsp.found, rsp.status == ST_OK, "hit with bad status")

endmodule

bind array_list_engine ale_checker u_ale_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

@@ tb/sv/array_list_engine_test.sv @@
`timescale 1ns / 1ps

module array_list_engine_test;
    import ale_pkg::*;

    localparam int LIST_CAP = 32;
    // codes outside the defined set; the block treats them as no-ops
    localparam logic [2:0] OP_NOP6 = 3'd6;
    localparam logic [2:0] OP_NOP7 = 3'd7;

    // list growth profiles for the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_CHURN = 2;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    always #1 clk = ~clk;

    array_list_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    // mirror of the list contents and length
    logic [31:0] list_mem [LIST_CAP];
    int unsigned list_len = 0;

    rsp_t        pending_rsp [$];
    int unsigned err_cnt = 0;
    bit          idle_on = 1'b1;

    // cumulative op weights per mode: append, insert, remove last,
    // remove at, overwrite, search; the rest goes to unused codes
    int unsigned op_cuts [0:2][0:5] = '{
        '{40, 70, 75, 80, 87, 95},
        '{ 6, 12, 40, 68, 78, 97},
        '{15, 32, 45, 60, 75, 97}
    };

    typedef struct {
        req_t rq;
        bit   typed;
        rsp_t rs;
    } dir_row_t;

    dir_row_t dir_rows [$];

    // apply one request to the mirror and return the result it should give
    function automatic rsp_t apply_list_op(req_t r);
        rsp_t o;
        int   i;
        o = '0;
        o.status = ST_OK;
        case (r.op)
            OP_APPEND:
                if (list_len >= LIST_CAP) o.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = r.value;
                    list_len++;
                end
            OP_INSERT:
                if (list_len >= LIST_CAP) o.status = ST_FULL;
                else if (r.position > list_len) o.status = ST_BADPOS;
                else
                begin
                    for (i = list_len; i > r.position; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[r.position] = r.value;
                    list_len++;
                end
            OP_REMOVE_LAST:
                if (list_len == 0) o.status = ST_EMPTY;
                else list_len--;
            OP_REMOVE_AT:
                if (list_len == 0) o.status = ST_EMPTY;
                else if (r.position >= list_len) o.status = ST_BADPOS;
                else
                begin
                    for (i = r.position; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                end
            OP_OVERWRITE:
                if (list_len == 0) o.status = ST_EMPTY;
                else if (r.position >= list_len) o.status = ST_BADPOS;
                else list_mem[r.position] = r.value;
            OP_SEARCH:
                for (i = 0; i < list_len && !o.found; i++)
                    if (list_mem[i] == r.value)
                    begin
                        o.found       = 1'b1;
                        o.found_index = i[4:0];
                    end
            default: ;
        endcase
        o.count    = list_len[5:0];
        o.is_empty = (list_len == 0);
        return o;
    endfunction

    function automatic dir_row_t mk_row(logic [2:0] op, logic [4:0] pos, logic [31:0] val,
                                        bit typed, logic [1:0] st, logic fnd,
                                        logic [4:0] idx, logic [5:0] cnt);
        dir_row_t d;
        d.rq.op          = op;
        d.rq.position    = pos;
        d.rq.value       = val;
        d.typed          = typed;
        d.rs.status      = st;
        d.rs.found       = fnd;
        d.rs.found_index = idx;
        d.rs.count       = cnt;
        d.rs.is_empty    = (cnt == 0);
        return d;
    endfunction

    // random request, biased toward valid positions and stored values
    function automatic req_t gen_req(int mode);
        req_t        r;
        int unsigned w;
        int unsigned k;
        int unsigned lim;
        int          i;
        w    = $urandom_range(99);
        r.op = ($urandom_range(1) == 0) ? OP_NOP6 : OP_NOP7;
        for (i = 5; i >= 0; i--)
            if (w < op_cuts[mode][i]) r.op = i[2:0];

        // position
        if (r.op == OP_INSERT) lim = (list_len >= LIST_CAP) ? LIST_CAP - 1 : list_len;
        else lim = (list_len > 0) ? list_len - 1 : LIST_CAP - 1;
        if ((r.op == OP_INSERT || r.op == OP_REMOVE_AT || r.op == OP_OVERWRITE)
            && $urandom_range(99) < 85)
            r.position = 5'($urandom_range(lim));
        else
            r.position = 5'($urandom_range(LIST_CAP - 1));

        // value: stored values give search hits, a small pool gives duplicates
        k = $urandom_range(99);
        if (k < 35 && list_len > 0) r.value = list_mem[$urandom_range(list_len - 1)];
        else if (k < 50) r.value = $urandom_range(3);
        else if (k < 58)
        begin
            case ($urandom_range(3))
                0: r.value = 32'h0000_0000;
                1: r.value = 32'hFFFF_FFFF;
                2: r.value = 32'hAAAA_AAAA;
                default: r.value = 32'h5555_5555;
            endcase
        end
        else r.value = $urandom;
        return r;
    endfunction

    // present one item and record its expected result once taken
    task automatic send_item(input req_t r, input bit typed, input rsp_t typed_rsp);
        rsp_t p;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 38)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        p = apply_list_op(r);
        pending_rsp.push_back(typed ? typed_rsp : p);
    endtask

    task automatic send_op(input logic [2:0] op, input logic [4:0] pos, input logic [31:0] val);
        req_t r;
        r.op       = op;
        r.position = pos;
        r.value    = val;
        send_item(r, 1'b0, '0);
    endtask

    // hold off until every outstanding result has come back
    task automatic settle_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, got %p", $time, rsp);
                err_cnt++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                cmp_field("status", want.status, rsp.status);
                cmp_field("found", want.found, rsp.found);
                cmp_field("found_index", want.found_index, rsp.found_index);
                cmp_field("count", want.count, rsp.count);
                cmp_field("is_empty", want.is_empty, rsp.is_empty);
            end
        end
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("[array_list_engine] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int mode;
        int n;

        // directed table: empty-list errors, boundaries, first-hit search
        dir_rows.push_back(mk_row(OP_REMOVE_LAST, 5'd0,  32'h0,         1, ST_EMPTY,  0, 0, 0));
        dir_rows.push_back(mk_row(OP_REMOVE_AT,   5'd0,  32'h0,         1, ST_EMPTY,  0, 0, 0));
        dir_rows.push_back(mk_row(OP_OVERWRITE,   5'd0,  32'h1,         1, ST_EMPTY,  0, 0, 0));
        dir_rows.push_back(mk_row(OP_SEARCH,      5'd0,  32'h0,         1, ST_OK,     0, 0, 0));
        dir_rows.push_back(mk_row(OP_INSERT,      5'd1,  32'h1,         1, ST_BADPOS, 0, 0, 0));
        dir_rows.push_back(mk_row(OP_NOP6,        5'd0,  32'h0,         1, ST_OK,     0, 0, 0));
        dir_rows.push_back(mk_row(OP_INSERT,      5'd0,  32'hFFFF_FFFF, 1, ST_OK,     0, 0, 1));
        dir_rows.push_back(mk_row(OP_APPEND,      5'd0,  32'h0,         1, ST_OK,     0, 0, 2));
        dir_rows.push_back(mk_row(OP_APPEND,      5'd31, 32'h8000_0001, 1, ST_OK,     0, 0, 3));
        dir_rows.push_back(mk_row(OP_INSERT,      5'd3,  32'h5,         1, ST_OK,     0, 0, 4));
        dir_rows.push_back(mk_row(OP_INSERT,      5'd31, 32'h9,         1, ST_BADPOS, 0, 0, 4));
        dir_rows.push_back(mk_row(OP_REMOVE_AT,   5'd4,  32'h0,         1, ST_BADPOS, 0, 0, 4));
        dir_rows.push_back(mk_row(OP_OVERWRITE,   5'd4,  32'h0,         1, ST_BADPOS, 0, 0, 4));
        dir_rows.push_back(mk_row(OP_OVERWRITE,   5'd31, 32'h0,         1, ST_BADPOS, 0, 0, 4));
        dir_rows.push_back(mk_row(OP_SEARCH,      5'd0,  32'hFFFF_FFFF, 1, ST_OK,     1, 0, 4));
        dir_rows.push_back(mk_row(OP_SEARCH,      5'd0,  32'h5,         1, ST_OK,     1, 3, 4));
        dir_rows.push_back(mk_row(OP_OVERWRITE,   5'd1,  32'h5,         1, ST_OK,     0, 0, 4));
        dir_rows.push_back(mk_row(OP_SEARCH,      5'd0,  32'h5,         1, ST_OK,     1, 1, 4));
        dir_rows.push_back(mk_row(OP_SEARCH,      5'd0,  32'h1234_5678, 1, ST_OK,     0, 0, 4));
        dir_rows.push_back(mk_row(OP_INSERT,      5'd0,  32'h7,         0, ST_OK,     0, 0, 0));
        dir_rows.push_back(mk_row(OP_REMOVE_AT,   5'd2,  32'h0,         0, ST_OK,     0, 0, 0));
        dir_rows.push_back(mk_row(OP_SEARCH,      5'd0,  32'h8000_0001, 0, ST_OK,     0, 0, 0));
        dir_rows.push_back(mk_row(OP_NOP7,        5'd31, 32'hFFFF_FFFF, 1, ST_OK,     0, 0, 4));
        dir_rows.push_back(mk_row(OP_REMOVE_LAST, 5'd0,  32'h0,         0, ST_OK,     0, 0, 0));
        dir_rows.push_back(mk_row(OP_SEARCH,      5'd0,  32'h5,         0, ST_OK,     0, 0, 0));

        // reset
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].rs);
        settle_results();

        // fill to capacity, then the full-list and longest-walk cases
        while (list_len < LIST_CAP)
            send_op(OP_APPEND, 5'($urandom_range(31)), $urandom);
        send_op(OP_APPEND, 5'd0, $urandom);
        send_op(OP_INSERT, 5'd0, $urandom);
        send_op(OP_INSERT, 5'd31, $urandom);
        send_op(OP_SEARCH, 5'd0, list_mem[LIST_CAP - 1]);
        send_op(OP_SEARCH, 5'd0, $urandom);
        send_op(OP_REMOVE_AT, 5'd0, 32'h0);
        send_op(OP_INSERT, 5'd0, 32'hFFFF_FFFF);
        send_op(OP_REMOVE_AT, 5'd31, 32'h0);
        send_op(OP_OVERWRITE, 5'd30, 32'h0);
        settle_results();

        // random part; one long stretch without sender gaps
        mode = MODE_DRAIN;
        for (n = 0; n < 400; n++)
        begin
            idle_on = !(n >= 150 && n < 250);
            if (n % 30 == 0) mode = $urandom_range(2);
            if (mode == MODE_FILL && list_len == LIST_CAP && $urandom_range(3) == 0)
                mode = MODE_CHURN;
            if (mode == MODE_DRAIN && list_len == 0 && $urandom_range(3) == 0)
                mode = MODE_FILL;
            if (n % 64 == 63) settle_results();
            send_item(gen_req(mode), 1'b0, '0);
        end

        // drain outstanding results, then idle before the final report
        settle_results();
        repeat (40) @(posedge clk);
        if (err_cnt == 0)
            $display("[array_list_engine] OK");
        else
            $display("[array_list_engine] ERROR");
        $finish;
    end

endmodule
